// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rstn, expr) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("assertion failed");
`else
`define ASSERT_PROP(name, clk, rstn, prop)
`define ASSERT_NEVER(name, clk, rstn, expr)
`endif
`endif

// ----- rtl/bzc_pkg.sv -----
// Types, constants and fixed-point helpers of the ZMP command core.
package bzc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD      = 32;
    localparam int DIV_LAT   = WORD + 2;
    localparam int EXP_LAT   = FRAC_BITS + 2;
    localparam int PIPE_LAT  = DIV_LAT + EXP_LAT + 9;
    localparam int CFG_W     = 3;
    localparam int EXP_BIAS  = FRAC_BITS - 30;

    typedef logic signed [WORD-1:0] fixed_t;
    typedef logic signed [2*WORD-1:0] wide_t;

    localparam fixed_t FIX_MAX  = {1'b0, {(WORD-1){1'b1}}};
    localparam fixed_t FIX_MIN  = {1'b1, {(WORD-1){1'b0}}};
    localparam fixed_t FIX_ONE  = fixed_t'(64'd1 << FRAC_BITS);
    localparam wide_t  WIDE_MAX = (2*WORD)'(FIX_MAX);
    localparam wide_t  WIDE_MIN = (2*WORD)'(FIX_MIN);
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    typedef enum logic [CFG_W-1:0] {
        CFG_ALONG_SUM  = 3'd0,
        CFG_ALONG_PROD = 3'd1,
        CFG_LAT_SUM    = 3'd2,
        CFG_LAT_PROD   = 3'd3,
        CFG_CURVATURE  = 3'd4,
        CFG_INV_RATE   = 3'd5,
        CFG_ACT_GAIN   = 3'd6,
        CFG_ACT_RATE   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        fixed_t along_error;
        fixed_t along_velocity;
        fixed_t lateral_error;
        fixed_t lateral_velocity;
        fixed_t desired_speed;
    } cmd_in_t;

    typedef struct packed {
        fixed_t zmp_along;
        fixed_t zmp_lateral;
        logic   overflow;
    } cmd_out_t;

    typedef struct packed {
        logic   ov;
        fixed_t val;
    } sres_t;

    function automatic sres_t sat_wide(input wide_t v);
        sres_t r;
        priority if (v > WIDE_MAX)
            r = '{1'b1, FIX_MAX};
        else if (v < WIDE_MIN)
            r = '{1'b1, FIX_MIN};
        else
            r = '{1'b0, v[WORD-1:0]};
        return r;
    endfunction

    function automatic sres_t fmul(input fixed_t a, input fixed_t b);
        wide_t p;
        p = (2*WORD)'(a) * (2*WORD)'(b);
        return sat_wide(p >>> FRAC_BITS);
    endfunction

    function automatic sres_t fadd(input fixed_t a, input fixed_t b);
        wide_t s;
        s = (2*WORD)'(a) + (2*WORD)'(b);
        return sat_wide(s);
    endfunction

    function automatic sres_t fsub(input fixed_t a, input fixed_t b);
        wide_t s;
        s = (2*WORD)'(a) - (2*WORD)'(b);
        return sat_wide(s);
    endfunction

    // elaboration only: factors 2^(2^-j) in Q30
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [30:0] exp_factor(input int j);
        logic [63:0] t;
        t = 64'd1 << 31;
        for (int k = 0; k < j; k++)
            t = isqrt64(t << 30);
        return t[30:0];
    endfunction

endpackage

// ----- rtl/bzc_div.sv -----
// Pipelined signed fixed-point divider, one quotient bit per stage, saturating.
module bzc_div (
    input  logic            clk,
    input  bzc_pkg::fixed_t a,
    input  bzc_pkg::fixed_t b,
    output bzc_pkg::fixed_t q,
    output logic            ov
);
    import bzc_pkg::*;

    typedef struct packed {
        logic [WORD-1:0] rem;
        logic [WORD-1:0] bits;
        logic [WORD-1:0] quo;
        logic [WORD-1:0] dmag;
        logic            neg;
        logic            zero;
        logic            big;
    } div_stage_t;

    div_stage_t st_reg  [WORD+1];
    div_stage_t st_next [WORD+1];
    logic [WORD-1:0] amag;
    logic [WORD-1:0] bmag;
    fixed_t q_reg;
    fixed_t q_next;
    logic   ov_reg;
    logic   ov_next;

    assign amag = a[WORD-1] ? WORD'(-a) : WORD'(a);
    assign bmag = b[WORD-1] ? WORD'(-b) : WORD'(b);

    // high quotient bits are zero unless big, so start past them
    assign st_next[0] = '{
        rem:  {{(WORD-FRAC_BITS){1'b0}}, amag[WORD-1:WORD-FRAC_BITS]},
        bits: {amag[WORD-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}},
        quo:  '0,
        dmag: bmag,
        neg:  a[WORD-1] ^ b[WORD-1],
        zero: (b == '0),
        big:  ({{FRAC_BITS{1'b0}}, amag} >= {bmag, {FRAC_BITS{1'b0}}})
    };

    for (genvar k = 1; k <= WORD; k++) begin : g_step
        logic [WORD:0] sh;
        logic [WORD:0] diff;
        logic          ge;
        assign sh   = {st_reg[k-1].rem, st_reg[k-1].bits[WORD-1]};
        assign diff = sh - {1'b0, st_reg[k-1].dmag};
        assign ge   = (sh >= {1'b0, st_reg[k-1].dmag});
        assign st_next[k] = '{
            rem:  ge ? diff[WORD-1:0] : sh[WORD-1:0],
            bits: {st_reg[k-1].bits[WORD-2:0], 1'b0},
            quo:  {st_reg[k-1].quo[WORD-2:0], ge},
            dmag: st_reg[k-1].dmag,
            neg:  st_reg[k-1].neg,
            zero: st_reg[k-1].zero,
            big:  st_reg[k-1].big
        };
    end

    always_comb
    begin
        q_next  = fixed_t'(st_reg[WORD].quo);
        ov_next = 1'b0;
        priority if (st_reg[WORD].zero)
        begin
            q_next  = '0;
            ov_next = 1'b1;
        end
        else if (st_reg[WORD].big)
        begin
            q_next  = st_reg[WORD].neg ? FIX_MIN : FIX_MAX;
            ov_next = 1'b1;
        end
        else if (st_reg[WORD].neg)
        begin
            if (st_reg[WORD].quo > WORD'(FIX_MIN))
            begin
                q_next  = FIX_MIN;
                ov_next = 1'b1;
            end
            else
            begin
                q_next = fixed_t'(-st_reg[WORD].quo);
            end
        end
        else if (st_reg[WORD].quo > WORD'(FIX_MAX))
        begin
            q_next  = FIX_MAX;
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= WORD; k++)
            st_reg[k] <= st_next[k];
        q_reg  <= q_next;
        ov_reg <= ov_next;
    end

    assign q  = q_reg;
    assign ov = ov_reg;

endmodule

// ----- rtl/bzc_exp.sv -----
// Pipelined fixed-point exponential: base-2 split, one fraction bit per stage.
module bzc_exp (
    input  logic                       clk,
    input  logic signed [bzc_pkg::WORD:0] x,
    output bzc_pkg::fixed_t            ex,
    output logic                       ov
);
    import bzc_pkg::*;

    typedef struct packed {
        logic [30:0]          m;
        logic [FRAC_BITS-1:0] f;
        logic                 big;
        logic                 tiny;
        logic [4:0]           sh;
    } exp_stage_t;

    exp_stage_t st_reg  [FRAC_BITS+1];
    exp_stage_t st_next [FRAC_BITS+1];
    wide_t  p;
    wide_t  y;
    wide_t  n;
    wide_t  s;
    fixed_t ex_reg;
    fixed_t ex_next;
    logic   ov_reg;

    assign p = (2*WORD)'(x) * (2*WORD)'($signed({1'b0, LOG2E_Q30}));
    assign y = p >>> 30;
    assign n = y >>> FRAC_BITS;
    assign s = n + (2*WORD)'(EXP_BIAS);

    assign st_next[0] = '{
        m:    31'd1 << 30,
        f:    y[FRAC_BITS-1:0],
        big:  (s > 0),
        tiny: (s <= -(64'sd32)),
        sh:   5'(-s)
    };

    for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_step
        localparam logic [30:0] FACTOR = exp_factor(j);
        logic [61:0] prod;
        assign prod = 62'(st_reg[j-1].m) * 62'(FACTOR);
        assign st_next[j] = '{
            m:    st_reg[j-1].f[FRAC_BITS-j] ? prod[60:30] : st_reg[j-1].m,
            f:    st_reg[j-1].f,
            big:  st_reg[j-1].big,
            tiny: st_reg[j-1].tiny,
            sh:   st_reg[j-1].sh
        };
    end

    always_comb
    begin
        priority if (st_reg[FRAC_BITS].big)
            ex_next = FIX_MAX;
        else if (st_reg[FRAC_BITS].tiny)
            ex_next = '0;
        else
            ex_next = fixed_t'({1'b0, st_reg[FRAC_BITS].m} >> st_reg[FRAC_BITS].sh);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= FRAC_BITS; k++)
            st_reg[k] <= st_next[k];
        ex_reg <= ex_next;
        ov_reg <= st_reg[FRAC_BITS].big;
    end

    assign ex = ex_reg;
    assign ov = ov_reg;

endmodule

// ----- rtl/biped_zmp_command_core.sv -----
// Top level of the biped ZMP command core: config registers and main pipeline.
// Fully pipelined: one item per cycle, each result appears on done/result in
// start order, with its done strobe. The depth PIPE_LAT is set by the 34-stage
// bit-per-stage dividers and the 18-stage exponential, plus nine arithmetic stages.
// busy stays low; there is no backpressure, so every result must be taken on its strobe.
`include "assert_macros.svh"

module biped_zmp_command_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bzc_pkg::cmd_in_t              cmd,
    output logic                          done,
    output bzc_pkg::cmd_out_t             result,
    input  logic                          cfg_we,
    input  logic [bzc_pkg::CFG_W-1:0]     cfg_index,
    input  bzc_pkg::fixed_t               cfg_data
);
    import bzc_pkg::*;

    typedef struct packed {
        fixed_t qw;
        fixed_t qu2;
        fixed_t lpdw;
        fixed_t dw2;
        fixed_t uza;
        logic   ov;
    } side_a_t;

    typedef struct packed {
        fixed_t qw;
        fixed_t lpdw;
        fixed_t uz;
        fixed_t k3;
        logic   ov;
    } side_b_t;

    // config
    fixed_t ags_reg, agp_reg, lgs_reg, lgp_reg, kap_reg;
    logic [30:0] iz_reg, ag_reg, ar_reg;
    fixed_t iz_f, ag_f, ar_f;

    logic accept;
    logic vld_reg [PIPE_LAT];

    // S1
    sres_t kdw_c, qu_c, qw_c, dw2_c, lpdw_c;
    fixed_t s1_kdw_reg, s1_qu_reg, s1_qw_reg, s1_dw2_reg, s1_lpdw_reg;
    fixed_t s1_du_reg, s1_vu_reg, s1_vd_reg;
    logic   s1_ov_reg;
    // S2
    sres_t r_c, rvd_c, pr_c, kqu_c, qw2_c, qu2_c;
    fixed_t s2_r_reg, s2_rvd_reg, s2_pr_reg, s2_kqu_reg, s2_qw2_reg, s2_qu2_reg;
    fixed_t s2_qw_reg, s2_du_reg, s2_vu_reg, s2_dw2_reg, s2_lpdw_reg;
    logic   s2_ov_reg;
    // S3
    sres_t e1_c, m1_c, m2_c, t_c;
    fixed_t s3_m1_reg, s3_m2_reg, s3_t_reg, s3_r_reg, s3_qw2_reg, s3_qu2_reg;
    fixed_t s3_qw_reg, s3_dw2_reg, s3_lpdw_reg;
    logic   s3_ov_reg;
    // S4
    sres_t uz1_c, uza_c, t2_c;
    fixed_t  s4_t2_reg, s4_r_reg, s4_qw2_reg;
    side_a_t s4_side_reg;
    side_a_t sa_dly_reg [DIV_LAT];
    side_a_t sa_d;
    // dividers
    fixed_t q_t2, q_d2, q_k;
    logic   ov_t2, ov_d2, ov_k;
    // S5
    sres_t d2_c, ad2_c, uz_c, k3_c;
    logic signed [WORD:0] s5_x_reg;
    side_b_t s5_side_reg;
    side_b_t sb_dly_reg [EXP_LAT];
    side_b_t sb_d;
    fixed_t  ex;
    logic    ex_ov;
    // S6..S9
    sres_t pa_c, act_c, la_c, w2_c, w3_c, wz_c;
    fixed_t  s6_act_reg, s7_la_reg, s8_w2_reg;
    side_b_t s6_side_reg, s7_side_reg, s8_side_reg;
    cmd_out_t result_reg;

    assign iz_f = fixed_t'({1'b0, iz_reg});
    assign ag_f = fixed_t'({1'b0, ag_reg});
    assign ar_f = fixed_t'({1'b0, ar_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ags_reg <= '0;
            agp_reg <= '0;
            lgs_reg <= '0;
            lgp_reg <= FIX_ONE;
            kap_reg <= '0;
            iz_reg  <= FIX_ONE[30:0];
            ag_reg  <= '0;
            ar_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ALONG_SUM:  ags_reg <= cfg_data;
                CFG_ALONG_PROD: agp_reg <= cfg_data;
                CFG_LAT_SUM:    lgs_reg <= cfg_data;
                CFG_LAT_PROD:   lgp_reg <= cfg_data;
                CFG_CURVATURE:  kap_reg <= cfg_data;
                CFG_INV_RATE:   iz_reg  <= cfg_data[30:0];
                CFG_ACT_GAIN:   ag_reg  <= cfg_data[30:0];
                CFG_ACT_RATE:   ar_reg  <= cfg_data[30:0];
            endcase
        end
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int i = 1; i < PIPE_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_comb
    begin
        // S1
        kdw_c  = fmul(kap_reg, cmd.lateral_error);
        qu_c   = fmul(cmd.along_velocity, iz_f);
        qw_c   = fmul(cmd.lateral_velocity, iz_f);
        dw2_c  = fmul(cmd.lateral_error, cmd.lateral_error);
        lpdw_c = fmul(lgp_reg, cmd.lateral_error);
        // S2: r = 1 - kappa*dw
        r_c    = fsub(FIX_ONE, s1_kdw_reg);
        rvd_c  = fmul(r_c.val, s1_vd_reg);
        pr_c   = fmul(agp_reg, r_c.val);
        kqu_c  = fmul(kap_reg, s1_qu_reg);
        qw2_c  = fmul(s1_qw_reg, s1_qw_reg);
        qu2_c  = fmul(s1_qu_reg, s1_qu_reg);
        // S3
        e1_c   = fsub(s2_vu_reg, s2_rvd_reg);
        m1_c   = fmul(e1_c.val, iz_f);
        m2_c   = fmul(s2_pr_reg, s2_du_reg);
        t_c    = fmul(s2_kqu_reg, s2_qw_reg);
        // S4
        uz1_c  = fmul(ags_reg, s3_m1_reg);
        uza_c  = fsub(uz1_c.val, s3_m2_reg);
        t2_c   = fadd(s3_t_reg, s3_t_reg);
        // S5
        d2_c   = fadd(sa_d.dw2, q_d2);
        ad2_c  = fmul(ar_f, d2_c.val);
        uz_c   = fadd(sa_d.uza, q_t2);
        k3_c   = fmul(q_k, sa_d.qu2);
        // S6..S9
        pa_c   = fmul(ag_f, ex);
        act_c  = fsub(FIX_ONE, pa_c.val);
        la_c   = fmul(lgs_reg, s6_act_reg);
        w2_c   = fmul(s7_la_reg, s7_side_reg.qw);
        w3_c   = fadd(s8_w2_reg, s8_side_reg.lpdw);
        wz_c   = fsub(w3_c.val, s8_side_reg.k3);
    end

    assign sa_d = sa_dly_reg[DIV_LAT-1];
    assign sb_d = sb_dly_reg[EXP_LAT-1];

    always_ff @(posedge clk)
    begin
        s1_kdw_reg  <= kdw_c.val;
        s1_qu_reg   <= qu_c.val;
        s1_qw_reg   <= qw_c.val;
        s1_dw2_reg  <= dw2_c.val;
        s1_lpdw_reg <= lpdw_c.val;
        s1_du_reg   <= cmd.along_error;
        s1_vu_reg   <= cmd.along_velocity;
        s1_vd_reg   <= cmd.desired_speed;
        s1_ov_reg   <= kdw_c.ov | qu_c.ov | qw_c.ov | dw2_c.ov | lpdw_c.ov;

        s2_r_reg    <= r_c.val;
        s2_rvd_reg  <= rvd_c.val;
        s2_pr_reg   <= pr_c.val;
        s2_kqu_reg  <= kqu_c.val;
        s2_qw2_reg  <= qw2_c.val;
        s2_qu2_reg  <= qu2_c.val;
        s2_qw_reg   <= s1_qw_reg;
        s2_du_reg   <= s1_du_reg;
        s2_vu_reg   <= s1_vu_reg;
        s2_dw2_reg  <= s1_dw2_reg;
        s2_lpdw_reg <= s1_lpdw_reg;
        s2_ov_reg   <= s1_ov_reg | r_c.ov | rvd_c.ov | pr_c.ov | kqu_c.ov
                       | qw2_c.ov | qu2_c.ov;

        s3_m1_reg   <= m1_c.val;
        s3_m2_reg   <= m2_c.val;
        s3_t_reg    <= t_c.val;
        s3_r_reg    <= s2_r_reg;
        s3_qw2_reg  <= s2_qw2_reg;
        s3_qu2_reg  <= s2_qu2_reg;
        s3_qw_reg   <= s2_qw_reg;
        s3_dw2_reg  <= s2_dw2_reg;
        s3_lpdw_reg <= s2_lpdw_reg;
        s3_ov_reg   <= s2_ov_reg | e1_c.ov | m1_c.ov | m2_c.ov | t_c.ov;

        s4_t2_reg   <= t2_c.val;
        s4_r_reg    <= s3_r_reg;
        s4_qw2_reg  <= s3_qw2_reg;
        s4_side_reg <= '{
            qw:   s3_qw_reg,
            qu2:  s3_qu2_reg,
            lpdw: s3_lpdw_reg,
            dw2:  s3_dw2_reg,
            uza:  uza_c.val,
            ov:   s3_ov_reg | uz1_c.ov | uza_c.ov | t2_c.ov
        };

        sa_dly_reg[0] <= s4_side_reg;
        for (int i = 1; i < DIV_LAT; i++)
            sa_dly_reg[i] <= sa_dly_reg[i-1];

        s5_x_reg    <= -((WORD+1)'(ad2_c.val));
        s5_side_reg <= '{
            qw:   sa_d.qw,
            lpdw: sa_d.lpdw,
            uz:   uz_c.val,
            k3:   k3_c.val,
            ov:   sa_d.ov | ov_t2 | ov_d2 | ov_k | d2_c.ov | ad2_c.ov
                  | uz_c.ov | k3_c.ov
        };

        sb_dly_reg[0] <= s5_side_reg;
        for (int i = 1; i < EXP_LAT; i++)
            sb_dly_reg[i] <= sb_dly_reg[i-1];

        s6_act_reg  <= act_c.val;
        s6_side_reg <= '{
            qw:   sb_d.qw,
            lpdw: sb_d.lpdw,
            uz:   sb_d.uz,
            k3:   sb_d.k3,
            ov:   sb_d.ov | ex_ov | pa_c.ov | act_c.ov
        };

        s7_la_reg   <= la_c.val;
        s7_side_reg <= '{
            qw:   s6_side_reg.qw,
            lpdw: s6_side_reg.lpdw,
            uz:   s6_side_reg.uz,
            k3:   s6_side_reg.k3,
            ov:   s6_side_reg.ov | la_c.ov
        };

        s8_w2_reg   <= w2_c.val;
        s8_side_reg <= '{
            qw:   s7_side_reg.qw,
            lpdw: s7_side_reg.lpdw,
            uz:   s7_side_reg.uz,
            k3:   s7_side_reg.k3,
            ov:   s7_side_reg.ov | w2_c.ov
        };

        result_reg <= '{
            zmp_along:   s8_side_reg.uz,
            zmp_lateral: wz_c.val,
            overflow:    s8_side_reg.ov | w3_c.ov | wz_c.ov
        };
    end

    bzc_div u_div_t2 (
        .clk (clk),
        .a   (s4_t2_reg),
        .b   (s4_r_reg),
        .q   (q_t2),
        .ov  (ov_t2)
    );

    bzc_div u_div_d2 (
        .clk (clk),
        .a   (s4_qw2_reg),
        .b   (lgp_reg),
        .q   (q_d2),
        .ov  (ov_d2)
    );

    bzc_div u_div_k (
        .clk (clk),
        .a   (kap_reg),
        .b   (s4_r_reg),
        .q   (q_k),
        .ov  (ov_k)
    );

    bzc_exp u_exp (
        .clk (clk),
        .x   (s5_x_reg),
        .ex  (ex),
        .ov  (ex_ov)
    );

    assign done   = vld_reg[PIPE_LAT-1];
    assign result = result_reg;

    `ASSERT_PROP(a_fixed_latency, clk, rst_n, start && !busy |-> ##PIPE_LAT done)
    `ASSERT_NEVER(a_no_orphan, clk, rst_n, done && !$past(start && !busy, PIPE_LAT))
    `ASSERT_PROP(a_r_zero_flag, clk, rst_n, vld_reg[3] && s4_r_reg == '0 |-> ##(PIPE_LAT-4) result.overflow)

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the biped ZMP command core.
module tb;
    import bzc_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    cmd_in_t   cmd;
    logic      done;
    cmd_out_t  result;
    logic      cfg_we;
    logic [CFG_W-1:0] cfg_index;
    fixed_t    cfg_data;

    biped_zmp_command_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    localparam int     LATENCY   = 61;
    localparam int     MAX_CYCLE = 400000;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam longint Q_ONE = 64'sd65536;
    localparam longint LOG2E = 64'sd1549082005;

    cmd_in_t  pend_q[$];
    cmd_out_t zmp_exp_q[$];
    longint   shadow[8];
    longint   pow2_factor[17];
    int       burst_left, gap_left, cycles, errors, n_items, n_results, n_ovf;

    function automatic longint sat32(input longint v, ref bit ov);
        if (v > Q_MAX) begin ov = 1; return Q_MAX; end
        if (v < Q_MIN) begin ov = 1; return Q_MIN; end
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b, ref bit ov);
        return sat32((a * b) >>> FRAC_BITS, ov);
    endfunction

    function automatic longint qadd(input longint a, input longint b, ref bit ov);
        return sat32(a + b, ov);
    endfunction

    function automatic longint qsub(input longint a, input longint b, ref bit ov);
        return sat32(a - b, ov);
    endfunction

    function automatic longint qdiv(input longint a, input longint b, ref bit ov);
        if (b == 0) begin ov = 1; return 0; end
        return sat32((a * Q_ONE) / b, ov);
    endfunction

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint qexp(input longint x, ref bit ov);
        longint y, n, f, s;
        longint unsigned m;
        y = (x * LOG2E) >>> 30;
        n = y >>> FRAC_BITS;
        f = y - (n <<< FRAC_BITS);
        m = 64'd1 << 30;
        for (int j = 1; j <= FRAC_BITS; j++)
            if (f[FRAC_BITS - j]) m = (m * pow2_factor[j]) >> 30;
        s = n + FRAC_BITS - 30;
        if (s > 0) begin ov = 1; return Q_MAX; end
        if (s <= -32) return 0;
        return longint'(m >> (-s));
    endfunction

    function automatic cmd_out_t zmp_predict(input cmd_in_t c);
        bit ov;
        longint du, vu, dw, vw, vd, iz, kap, r, qu, qw, t, uz, d2, ex, act, wz;
        cmd_out_t o;
        ov = 0;
        du = c.along_error; vu = c.along_velocity; dw = c.lateral_error;
        vw = c.lateral_velocity; vd = c.desired_speed;
        iz = shadow[CFG_INV_RATE]; kap = shadow[CFG_CURVATURE];
        r  = qsub(Q_ONE, qmul(kap, dw, ov), ov);
        qu = qmul(vu, iz, ov);
        qw = qmul(vw, iz, ov);
        uz = qmul(shadow[CFG_ALONG_SUM], qmul(qsub(vu, qmul(r, vd, ov), ov), iz, ov), ov);
        uz = qsub(uz, qmul(qmul(shadow[CFG_ALONG_PROD], r, ov), du, ov), ov);
        t  = qmul(qmul(kap, qu, ov), qw, ov);
        uz = qadd(uz, qdiv(qadd(t, t, ov), r, ov), ov);
        d2 = qadd(qmul(dw, dw, ov), qdiv(qmul(qw, qw, ov), shadow[CFG_LAT_PROD], ov), ov);
        ex = qexp(-qmul(shadow[CFG_ACT_RATE], d2, ov), ov);
        act = qsub(Q_ONE, qmul(shadow[CFG_ACT_GAIN], ex, ov), ov);
        wz = qmul(qmul(shadow[CFG_LAT_SUM], act, ov), qw, ov);
        wz = qadd(wz, qmul(shadow[CFG_LAT_PROD], dw, ov), ov);
        wz = qsub(wz, qmul(qdiv(kap, r, ov), qmul(qu, qu, ov), ov), ov);
        o.zmp_along = fixed_t'(uz);
        o.zmp_lateral = fixed_t'(wz);
        o.overflow = ov;
        return o;
    endfunction

    function automatic fixed_t rand_fix();
        case ($urandom_range(0, 5))
            0, 1: return fixed_t'($urandom);
            2:    return fixed_t'($signed($urandom_range(0, 2**19)) - 2**18);
            3:    return fixed_t'($signed($urandom_range(0, 2**13)) - 2**12);
            4:    return $urandom_range(0, 1) ? FIX_MAX : FIX_MIN;
            default: return fixed_t'($signed($urandom_range(0, 2**17)) - 2**16);
        endcase
    endfunction

    function automatic cmd_in_t rand_cmd();
        cmd_in_t c;
        c.along_error = rand_fix();
        c.along_velocity = rand_fix();
        c.lateral_error = rand_fix();
        c.lateral_velocity = rand_fix();
        c.desired_speed = rand_fix();
        return c;
    endfunction

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // sender: bursts with random gaps
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 0;
            cmd <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!(start && busy)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 0;
            end else if (pend_q.size() > 0) begin
                start <= 1;
                cmd <= pend_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end else
                    burst_left <= burst_left - 1;
            end else
                start <= 0;
        end
    end

    // monitor: predict on accept, check on strobe
    always @(posedge clk) begin
        cmd_out_t e;
        if (rst_n) begin
            if (start && !busy) begin
                zmp_exp_q.push_back(zmp_predict(cmd));
                n_items++;
            end
            if (cfg_we) begin
                if (cfg_index >= CFG_INV_RATE)
                    shadow[cfg_index] = longint'({1'b0, cfg_data[30:0]});
                else
                    shadow[cfg_index] = longint'(cfg_data);
            end
            if (done) begin
                n_results++;
                if (zmp_exp_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, result);
                    errors++;
                end else begin
                    e = zmp_exp_q.pop_front();
                    n_ovf += e.overflow;
                    if (result.zmp_along !== e.zmp_along)
                        $display("%0t: zmp_along exp %h got %h", $time, e.zmp_along,
                                 result.zmp_along);
                    if (result.zmp_lateral !== e.zmp_lateral)
                        $display("%0t: zmp_lateral exp %h got %h", $time, e.zmp_lateral,
                                 result.zmp_lateral);
                    if (result.overflow !== e.overflow)
                        $display("%0t: overflow exp %b got %b", $time, e.overflow,
                                 result.overflow);
                    if (result !== e) errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > MAX_CYCLE) begin
            $display("timeout");
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic cfg_write(input cfg_idx_t idx, input fixed_t val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic cfg_all(input fixed_t v[8]);
        for (int i = 0; i < 8; i++) cfg_write(cfg_idx_t'(i), v[i]);
    endtask

    task automatic drain();
        do @(posedge clk); while (pend_q.size() || start || zmp_exp_q.size());
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic push_cmd(input fixed_t a, b, c, d, e);
        cmd_in_t x;
        x = '{a, b, c, d, e};
        pend_q.push_back(x);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) pend_q.push_back(rand_cmd());
        drain();
    endtask

    initial begin
        fixed_t v[8];
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0; n_items = 0; n_results = 0; n_ovf = 0; cycles = 0;
        shadow = '{0, 0, 0, 65536, 0, 65536, 0, 0};
        pow2_factor[0] = 64'd1 << 31;
        for (int j = 1; j <= 16; j++) pow2_factor[j] = int_sqrt(pow2_factor[j-1] << 30);
        repeat (3) @(posedge clk);
        rst_n <= 1;

        // reset settings, then directed items
        push_cmd(0, 0, 0, 0, 0);
        push_cmd(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX);
        push_cmd(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN);
        push_cmd(FIX_ONE, -FIX_ONE, FIX_ONE, -FIX_ONE, FIX_ONE);
        run_random(60);

        // typical gains, curvature 1.0 so lateral_error 1.0 gives r zero
        v = '{32'sh0003_0000, 32'sh0002_0000, 32'sh0004_0000, 32'sh0003_8000,
              32'sh0001_0000, 32'sh0000_C000, 32'sh0000_8000, 32'sh0002_0000};
        cfg_all(v);
        push_cmd(FIX_ONE, FIX_ONE, FIX_ONE, FIX_ONE, FIX_ONE);
        push_cmd(-FIX_ONE, 32'sh8000, FIX_ONE, -32'sh8000, 32'sh2_0000);
        push_cmd(32'sh1234, 32'sh5678, 32'sh100, 32'sh200, 32'sh300);
        push_cmd(0, FIX_MAX, 0, FIX_MIN, 0);
        run_random(200);

        // lateral gain product zero
        v[CFG_LAT_PROD] = 0;
        cfg_all(v);
        push_cmd(FIX_ONE, FIX_ONE, 32'sh8000, FIX_ONE, FIX_ONE);
        run_random(120);

        // negative lateral product drives d2 negative: exponential too large
        v = '{32'sh0001_0000, -32'sh0001_0000, -32'sh0002_0000, -32'sh0000_1000,
              -32'sh0000_4000, 32'sh0001_0000, 32'sh0001_0000, 32'sh7FFF_FFFF};
        cfg_all(v);
        push_cmd(0, 0, 0, FIX_ONE, 0);
        push_cmd(0, 0, 32'sh100, 32'sh10_0000, 0);
        run_random(150);

        // extremes
        v = '{FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX};
        cfg_all(v);
        push_cmd(FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX);
        run_random(120);
        v = '{FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, 0, 0, 0};
        cfg_all(v);
        push_cmd(FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN);
        run_random(120);

        // random settings, mostly moderate
        for (int p = 0; p < 4; p++) begin
            for (int i = 0; i < 8; i++)
                v[i] = ($urandom_range(0, 3) == 0) ? fixed_t'($urandom)
                       : fixed_t'($signed($urandom_range(0, 2**19)) - 2**18);
            v[CFG_INV_RATE] = $urandom_range(1, 2**18);
            v[CFG_ACT_GAIN] = $urandom_range(0, 2**17);
            v[CFG_ACT_RATE] = $urandom_range(0, 2**18);
            cfg_all(v);
            run_random(80);
        end

        $display("%0d items checked, %0d results, %0d flagged overflow, over 10 settings",
                 n_items, n_results, n_ovf);
        if (errors == 0 && zmp_exp_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
